FILE: hw/rtl/jsu_pkg.sv
// Shared types, character codes and decode helpers for the JSON string unescaper.
package jsu_pkg;

    // Result status codes
    typedef enum logic [2:0] {
        ST_BYTE       = 3'd0,
        ST_CLOSED     = 3'd1,
        ST_BAD_ESC    = 3'd2,
        ST_BAD_UNI    = 3'd3,
        ST_UNTERM_ESC = 3'd4,
        ST_UNTERM_STR = 3'd5,
        ST_NO_QUOTE   = 3'd6
    } status_t;

    // Front-end decoder state
    typedef enum logic [2:0] {
        MODE_WAIT    = 3'd0,
        MODE_BODY    = 3'd1,
        MODE_ESC     = 3'd2,
        MODE_HEX     = 3'd3,
        MODE_HOLD    = 3'd4,
        MODE_HOLD_BS = 3'd5,
        MODE_HEX2    = 3'd6
    } mode_t;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;

    localparam logic [15:0] HIGH_SURR_LO = 16'hD800;
    localparam logic [15:0] HIGH_SURR_HI = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_LO  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_HI  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE    = 21'h10000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result slots of one request: four for the first code point, four for
    // the second, one for the trailing byte or status.
    localparam int SLOTS = 9;

    // One request's results in compact form: up to two code points, then
    // an optional raw byte or status.
    typedef struct packed {
        logic        a_vld;
        logic [20:0] a_cp;
        logic        b_vld;
        logic [15:0] b_cp;
        logic        t_vld;
        logic [7:0]  t_byte;
        status_t     t_stat;
    } entry_t;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [3:0]      mask;
    } utf8_t;

    // {valid, value} of a hex digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
            r = {1'b1, 4'(c[3:0] + 4'd9)};
        end
        return r;
    endfunction

    // {valid, byte} of a single-letter escape
    function automatic logic [8:0] simple_escape(input logic [7:0] c);
        logic [8:0] r;
        r = '0;
        unique case (c)
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h2F:   r = {1'b1, 8'h2F};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h72:   r = {1'b1, 8'h0D};
            8'h74:   r = {1'b1, 8'h09};
            default: r = '0;
        endcase
        return r;
    endfunction

    // UTF-8 encode, first byte in lane 0
    function automatic utf8_t utf8_encode(input logic [20:0] cp);
        utf8_t r;
        r = '0;
        if (cp <= 21'h7F) begin
            r.bytes[0] = cp[7:0];
            r.mask     = 4'b0001;
        end
        else if (cp <= 21'h7FF) begin
            r.bytes[0] = {3'b110, cp[10:6]};
            r.bytes[1] = {2'b10, cp[5:0]};
            r.mask     = 4'b0011;
        end
        else if (cp <= 21'hFFFF) begin
            r.bytes[0] = {4'b1110, cp[15:12]};
            r.bytes[1] = {2'b10, cp[11:6]};
            r.bytes[2] = {2'b10, cp[5:0]};
            r.mask     = 4'b0111;
        end
        else begin
            r.bytes[0] = {5'b11110, cp[20:18]};
            r.bytes[1] = {2'b10, cp[17:12]};
            r.bytes[2] = {2'b10, cp[11:6]};
            r.bytes[3] = {2'b10, cp[5:0]};
            r.mask     = 4'b1111;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/json_string_unescape_utf8.sv
// JSON string unescaper: takes one text byte per request, starting at the opening quote,
// and delivers the decoded string as UTF-8 bytes followed by a closing or error status.
// Plain bytes pass through unchanged; \" \\ \/ \b \f \n \r \t and \uXXXX are decoded, a
// high surrogate directly followed by a \u low surrogate becomes one 4-byte code point,
// and any unpaired surrogate is encoded alone as 3 bytes. Every status (closed, bad
// escape, bad unicode, unterminated escape, unterminated string, no opening quote) ends
// the string and the block then waits for the next opening quote. Each input request
// yields zero to six result requests; the last one of them carries last = 1, and a
// request that only advances the decoder yields nothing. Throughput: one input request
// per cycle while the queue has room, one result per cycle while out_ready is high; an
// input with several results holds the output until all are out, and the four-entry queue
// between the decoder and the byte expander absorbs such bursts before the input stalls.
// Requests pass the queue, expander slots and output register. No clearing pass after reset.
module json_string_unescape_utf8 (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       text_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [2:0] status,
    output logic       last
);

    // decoder to queue
    logic            q_push;
    logic            q_push_ready;
    jsu_pkg::entry_t q_push_data;

    // queue to expander
    logic            q_pop;
    logic            q_pop_valid;
    jsu_pkg::entry_t q_pop_data;

    // Decode: track quote/escape/hex/surrogate state, emit compact requests
    jsu_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .char_in  (char_in),
        .text_end (text_end),
        .q_ready  (q_push_ready),
        .q_push   (q_push),
        .q_entry  (q_push_data)
    );

    // Buffer: decouple decoder stalls from output back-pressure
    jsu_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .push_ready (q_push_ready),
        .pop        (q_pop),
        .pop_valid  (q_pop_valid),
        .pop_data   (q_pop_data)
    );

    // Expand: encode code points to UTF-8 and stream results one per cycle while out_ready is high
    jsu_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_pop_valid),
        .q_entry   (q_pop_data),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .status    (status),
        .last      (last)
    );

endmodule

FILE: hw/rtl/jsu_front.sv
// Front end: accepts text bytes, tracks escape state and emits compact result requests.
module jsu_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [7:0]      char_in,
    input  logic            text_end,
    input  logic            q_ready,
    output logic            q_push,
    output jsu_pkg::entry_t q_entry
);

    jsu_pkg::mode_t mode_reg, mode_next;
    logic [15:0]    hex_value_reg, hex_value_next;
    logic [1:0]     hex_count_reg, hex_count_next;
    logic [15:0]    pending_high_reg, pending_high_next;

    logic            accept;
    logic [4:0]      hex;
    logic            hex_ok;
    logic [15:0]     hv_new;
    logic [8:0]      esc;
    jsu_pkg::entry_t ent;

    // escape-letter outcome, shared by the plain and held-surrogate paths
    jsu_pkg::mode_t   el_mode;
    logic             el_go_wait;
    logic             el_is_u;
    logic [7:0]       el_byte;
    jsu_pkg::status_t el_stat;

    assign in_ready = q_ready;
    assign accept   = in_valid && q_ready;
    assign q_push   = accept && (ent.a_vld || ent.b_vld || ent.t_vld);
    assign q_entry  = ent;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg         <= jsu_pkg::MODE_WAIT;
            hex_value_reg    <= '0;
            hex_count_reg    <= '0;
            pending_high_reg <= '0;
        end
        else if (accept) begin
            mode_reg         <= mode_next;
            hex_value_reg    <= hex_value_next;
            hex_count_reg    <= hex_count_next;
            pending_high_reg <= pending_high_next;
        end
    end

    always_comb begin
        hex    = jsu_pkg::hex_digit(char_in);
        hex_ok = !text_end && hex[4];
        hv_new = {hex_value_reg[11:0], hex[3:0]};
        esc    = jsu_pkg::simple_escape(char_in);

        el_mode    = jsu_pkg::MODE_WAIT;
        el_go_wait = 1'b1;
        el_is_u    = 1'b0;
        el_byte    = '0;
        el_stat    = jsu_pkg::ST_UNTERM_ESC;
        if (text_end) begin
            el_stat = jsu_pkg::ST_UNTERM_ESC;
        end
        else if (char_in == jsu_pkg::CH_U) begin
            el_is_u    = 1'b1;
            el_go_wait = 1'b0;
            el_mode    = jsu_pkg::MODE_HEX;
        end
        else if (esc[8]) begin
            el_go_wait = 1'b0;
            el_mode    = jsu_pkg::MODE_BODY;
            el_byte    = esc[7:0];
            el_stat    = jsu_pkg::ST_BYTE;
        end
        else begin
            el_stat = jsu_pkg::ST_BAD_ESC;
        end

        mode_next         = mode_reg;
        hex_value_next    = hex_value_reg;
        hex_count_next    = hex_count_reg;
        pending_high_next = pending_high_reg;
        ent               = '0;
        ent.t_stat        = jsu_pkg::ST_BYTE;

        unique case (mode_reg)
            jsu_pkg::MODE_BODY: begin
                if (text_end) begin
                    mode_next         = jsu_pkg::MODE_WAIT;
                    pending_high_next = '0;
                    ent.t_vld         = 1'b1;
                    ent.t_stat        = jsu_pkg::ST_UNTERM_STR;
                end
                else if (char_in == jsu_pkg::CH_QUOTE) begin
                    mode_next         = jsu_pkg::MODE_WAIT;
                    pending_high_next = '0;
                    ent.t_vld         = 1'b1;
                    ent.t_stat        = jsu_pkg::ST_CLOSED;
                end
                else if (char_in == jsu_pkg::CH_BSLASH) begin
                    mode_next = jsu_pkg::MODE_ESC;
                end
                else begin
                    ent.t_vld  = 1'b1;
                    ent.t_byte = char_in;
                end
            end
            jsu_pkg::MODE_ESC: begin
                mode_next = el_mode;
                if (el_is_u) begin
                    hex_value_next = '0;
                    hex_count_next = '0;
                end
                else begin
                    ent.t_vld  = 1'b1;
                    ent.t_byte = el_byte;
                    ent.t_stat = el_stat;
                    if (el_go_wait) begin
                        pending_high_next = '0;
                    end
                end
            end
            jsu_pkg::MODE_HEX, jsu_pkg::MODE_HEX2: begin
                if (!hex_ok) begin
                    if (mode_reg == jsu_pkg::MODE_HEX2) begin
                        ent.a_vld = 1'b1;
                        ent.a_cp  = {5'b0, pending_high_reg};
                    end
                    mode_next         = jsu_pkg::MODE_WAIT;
                    pending_high_next = '0;
                    ent.t_vld         = 1'b1;
                    ent.t_stat        = jsu_pkg::ST_BAD_UNI;
                end
                else begin
                    hex_value_next = hv_new;
                    if (hex_count_reg != 2'd3) begin
                        hex_count_next = 2'(hex_count_reg + 2'd1);
                    end
                    else begin
                        hex_count_next = '0;
                        if (mode_reg == jsu_pkg::MODE_HEX2) begin
                            pending_high_next = '0;
                            if (hv_new >= jsu_pkg::LOW_SURR_LO &&
                                hv_new <= jsu_pkg::LOW_SURR_HI) begin
                                // surrogate pair: combine into a supplementary code point
                                mode_next = jsu_pkg::MODE_BODY;
                                ent.a_vld = 1'b1;
                                ent.a_cp  = 21'(jsu_pkg::SUPP_BASE +
                                    {1'b0, pending_high_reg[9:0], hv_new[9:0]});
                            end
                            else begin
                                ent.a_vld = 1'b1;
                                ent.a_cp  = {5'b0, pending_high_reg};
                                if (hv_new >= jsu_pkg::HIGH_SURR_LO &&
                                    hv_new <= jsu_pkg::HIGH_SURR_HI) begin
                                    pending_high_next = hv_new;
                                    mode_next         = jsu_pkg::MODE_HOLD;
                                end
                                else begin
                                    mode_next = jsu_pkg::MODE_BODY;
                                    ent.b_vld = 1'b1;
                                    ent.b_cp  = hv_new;
                                end
                            end
                        end
                        else begin
                            if (hv_new >= jsu_pkg::HIGH_SURR_LO &&
                                hv_new <= jsu_pkg::HIGH_SURR_HI) begin
                                pending_high_next = hv_new;
                                mode_next         = jsu_pkg::MODE_HOLD;
                            end
                            else begin
                                mode_next = jsu_pkg::MODE_BODY;
                                ent.a_vld = 1'b1;
                                ent.a_cp  = {5'b0, hv_new};
                            end
                        end
                    end
                end
            end
            jsu_pkg::MODE_HOLD: begin
                if (!text_end && char_in == jsu_pkg::CH_BSLASH) begin
                    mode_next = jsu_pkg::MODE_HOLD_BS;
                end
                else begin
                    ent.a_vld         = 1'b1;
                    ent.a_cp          = {5'b0, pending_high_reg};
                    pending_high_next = '0;
                    ent.t_vld         = 1'b1;
                    if (text_end) begin
                        mode_next  = jsu_pkg::MODE_WAIT;
                        ent.t_stat = jsu_pkg::ST_UNTERM_STR;
                    end
                    else if (char_in == jsu_pkg::CH_QUOTE) begin
                        mode_next  = jsu_pkg::MODE_WAIT;
                        ent.t_stat = jsu_pkg::ST_CLOSED;
                    end
                    else begin
                        mode_next  = jsu_pkg::MODE_BODY;
                        ent.t_byte = char_in;
                    end
                end
            end
            jsu_pkg::MODE_HOLD_BS: begin
                if (el_is_u) begin
                    hex_value_next = '0;
                    hex_count_next = '0;
                    mode_next      = jsu_pkg::MODE_HEX2;
                end
                else begin
                    // flush the lone high surrogate, then treat the letter as usual
                    ent.a_vld         = 1'b1;
                    ent.a_cp          = {5'b0, pending_high_reg};
                    pending_high_next = '0;
                    mode_next         = el_mode;
                    ent.t_vld         = 1'b1;
                    ent.t_byte        = el_byte;
                    ent.t_stat        = el_stat;
                end
            end
            default: begin
                // waiting for the opening quote; unused codes land here too
                if (text_end || char_in != jsu_pkg::CH_QUOTE) begin
                    mode_next         = jsu_pkg::MODE_WAIT;
                    pending_high_next = '0;
                    ent.t_vld         = 1'b1;
                    ent.t_stat        = jsu_pkg::ST_NO_QUOTE;
                end
                else begin
                    mode_next = jsu_pkg::MODE_BODY;
                end
            end
        endcase
    end

endmodule

FILE: hw/rtl/jsu_queue.sv
// Short request queue between the decoder front end and the output back end.
module jsu_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  jsu_pkg::entry_t push_data,
    output logic            push_ready,
    input  logic            pop,
    output logic            pop_valid,
    output jsu_pkg::entry_t pop_data
);

    jsu_pkg::entry_t                  mem [jsu_pkg::QUEUE_DEPTH];
    logic [jsu_pkg::QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [jsu_pkg::QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [jsu_pkg::QCNT_W-1:0]       count_reg, count_next;
    logic                             do_push, do_pop;

    assign push_ready = count_reg != jsu_pkg::QCNT_W'(jsu_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == jsu_pkg::QPTR_W'(jsu_pkg::QUEUE_DEPTH - 1))
                        ? '0 : jsu_pkg::QPTR_W'(wr_ptr_reg + 1'b1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == jsu_pkg::QPTR_W'(jsu_pkg::QUEUE_DEPTH - 1))
                        ? '0 : jsu_pkg::QPTR_W'(rd_ptr_reg + 1'b1);
        end
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = jsu_pkg::QCNT_W'(count_reg + 1'b1);
        end
        else if (do_pop && !do_push) begin
            count_next = jsu_pkg::QCNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: hw/rtl/jsu_back.sv
// Back end: expands each request into UTF-8 bytes and statuses, one result per cycle while out_ready is high.
module jsu_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  jsu_pkg::entry_t q_entry,
    output logic            q_pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic [2:0]      status,
    output logic            last
);

    logic [jsu_pkg::SLOTS-1:0]      mask_reg, mask_next;
    logic [jsu_pkg::SLOTS-1:0][7:0] slot_byte_reg, slot_byte_next;
    jsu_pkg::status_t               tail_stat_reg;

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    jsu_pkg::status_t status_reg;
    logic             last_reg;

    jsu_pkg::utf8_t            enc_a, enc_b;
    logic [jsu_pkg::SLOTS-1:0] new_mask;
    logic [jsu_pkg::SLOTS-1:0] pick_oh, rest;
    logic [7:0]                pick_byte;
    logic                      adv, take, load;

    always_comb begin
        enc_a    = jsu_pkg::utf8_encode(q_entry.a_cp);
        enc_b    = jsu_pkg::utf8_encode({5'b0, q_entry.b_cp});
        new_mask = {q_entry.t_vld, enc_b.mask & {4{q_entry.b_vld}},
                    enc_a.mask & {4{q_entry.a_vld}}};
        slot_byte_next = {q_entry.t_byte, enc_b.bytes, enc_a.bytes};

        // lowest pending slot goes out next
        pick_oh   = mask_reg & jsu_pkg::SLOTS'(~mask_reg + 1'b1);
        rest      = mask_reg & ~pick_oh;
        pick_byte = '0;
        for (int i = 0; i < jsu_pkg::SLOTS; i++) begin
            pick_byte = pick_byte | (slot_byte_reg[i] & {8{pick_oh[i]}});
        end

        adv   = !out_valid_reg || out_ready;
        take  = adv && (mask_reg != '0);
        load  = (mask_reg == '0) || (take && rest == '0);
        q_pop = load && q_valid;

        if (load) begin
            mask_next = q_valid ? new_mask : '0;
        end
        else if (take) begin
            mask_next = rest;
        end
        else begin
            mask_next = mask_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            mask_reg <= mask_next;
            if (adv) begin
                out_valid_reg <= take;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (q_pop) begin
            slot_byte_reg <= slot_byte_next;
            tail_stat_reg <= q_entry.t_stat;
        end
        if (take) begin
            out_byte_reg <= pick_byte;
            status_reg   <= pick_oh[jsu_pkg::SLOTS-1] ? tail_stat_reg : jsu_pkg::ST_BYTE;
            last_reg     <= rest == '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign status    = status_reg;
    assign last      = last_reg;

endmodule

FILE: hw/rtl/jsu_checker.sv
// Port-level checks for the JSON string unescaper, bound to the top level.
module jsu_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [2:0] status,
    input logic       last
);

    // hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status)
                                    && $stable(last))
        else $error("stalled result changed");

    // a status always ends the results of its request
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != jsu_pkg::ST_BYTE |-> last)
        else $error("status result not marked last");

    // status results carry a zero byte
    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != jsu_pkg::ST_BYTE |-> out_byte == 8'h00)
        else $error("status result with nonzero byte");

    // ready and idle right after reset
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> in_ready && !out_valid)
        else $error("not idle right after reset");

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .status    (status),
    .last      (last)
);
